/* rtl/core/cbl_pkg.sv */
// cbl_pkg: shared types and constants of the codebook background learner
// no dependencies
`timescale 1ns / 1ps
package cbl_pkg;

  // default sizing
  localparam int DEF_CHANNELS    = 3;
  localparam int DEF_MAX_ENTRIES = 8;
  localparam int DEF_PIXELS      = 1024;

  // field widths fixed by the interface
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 8;
  localparam int TS_W    = 16;
  localparam int TOUCH_W = 3;
  localparam int USED_W  = 4;
  localparam int CFG_IW  = 2;

  localparam logic [VAL_W-1:0] PIX_TOP = 8'd255;
  localparam logic [VAL_W-1:0] BOUND_RST = 8'd10;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_BOUND0 = 2'd0,
    CFG_BOUND1 = 2'd1,
    CFG_BOUND2 = 2'd2
  } cfg_reg_e;

  // what one channel lane reports for one stored entry
  typedef struct packed {
    logic             in_win;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] ll_next;
    logic [VAL_W-1:0] lh_next;
    logic [VAL_W-1:0] smin_next;
    logic [VAL_W-1:0] smax_next;
  } lane_res_t;

endpackage

/* rtl/core/cbl_if.sv */
// cbl_if: valid/ready channels for pixel words and result words
// depends on cbl_pkg
`timescale 1ns / 1ps
interface cbl_in_if;
  logic                       valid;
  logic                       ready;
  logic [cbl_pkg::IDX_W-1:0]  pixel_index;
  logic [cbl_pkg::VAL_W-1:0]  chan0_value;
  logic [cbl_pkg::VAL_W-1:0]  chan1_value;
  logic [cbl_pkg::VAL_W-1:0]  chan2_value;

  modport source (output valid, pixel_index, chan0_value, chan1_value, chan2_value,
                  input ready);
  modport sink (input valid, pixel_index, chan0_value, chan1_value, chan2_value,
                output ready);
endinterface

interface cbl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         matched;
  logic [cbl_pkg::TOUCH_W-1:0]  touched_entry;
  logic                         created;
  logic                         book_full;
  logic [cbl_pkg::USED_W-1:0]   entries_used;

  modport source (output valid, matched, touched_entry, created, book_full, entries_used,
                  input ready);
  modport sink (input valid, matched, touched_entry, created, book_full, entries_used,
                output ready);
endinterface

/* rtl/core/codebook_background_learn_unit.sv */
// Codebook background learner: per-pixel codebook of up to MAX_ENTRIES entries.
// Flow: an accepted item passes the modulo steps (none when PIXELS >= 1024), the
//   count read, the walk over the entries stored at that pixel, the final write and
//   the result load, which waits until the previous word is taken; then the next item is taken.
// Throughput: one item in work at a time; the entry walk reads one entry per cycle from the entry RAM.
// Reset: a clearing pass over every pixel address zeroes the per-pixel count RAM; no word
//   is accepted until it ends. Bounds reset to 10; entry storage is not cleared.
`timescale 1ns / 1ps
module codebook_background_learn_unit #(
  parameter int CHANNELS    = cbl_pkg::DEF_CHANNELS,
  parameter int MAX_ENTRIES = cbl_pkg::DEF_MAX_ENTRIES,
  parameter int PIXELS      = cbl_pkg::DEF_PIXELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cbl_pkg::CFG_IW-1:0] cfg_index,
  input  logic [cbl_pkg::VAL_W-1:0]  cfg_data,
  cbl_in_if.sink                     pix_in,
  cbl_out_if.source                  res_out
);
  import cbl_pkg::*;

  localparam int PIX_AW  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int EW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int META_W  = CNT_W + TS_W;
  localparam int CH_W    = 4 * VAL_W;
  localparam int ENT_W   = CHANNELS * CH_W + 2 * TS_W;
  localparam int LAST_LO = CHANNELS * CH_W;
  localparam int STALE_LO = LAST_LO + TS_W;
  localparam int ENT_D   = PIXELS * (2 ** EW);
  localparam int RED_STEPS = (PIXELS > 1023) ? 0 : $clog2(1023 / PIXELS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RED, ST_META, ST_META_RD, ST_WALK, ST_FIN, ST_DONE
  } state_t;

  state_t state;

  logic [VAL_W-1:0]  bound0, bound1, bound2;
  logic [VAL_W-1:0]  v0, v1, v2;
  logic [IDX_W-1:0]  red_val;
  logic [3:0]        red_step;
  logic [PIX_AW-1:0] clr_addr;
  logic [CNT_W-1:0]  cnt;
  logic [TS_W-1:0]   tstamp;
  logic [CNT_W-1:0]  rd_idx;
  logic              pv;
  logic [EW-1:0]     pidx;
  logic              found;
  logic [EW-1:0]     hit;

  logic              out_valid;
  logic              out_matched, out_created, out_full;
  logic [TOUCH_W-1:0] out_touched;
  logic [USED_W-1:0]  out_used;

  logic [PIX_AW-1:0] loc;
  logic [31:0]       red_div;
  logic              meta_we;
  logic [PIX_AW-1:0] meta_waddr;
  logic [META_W-1:0] meta_wdata, meta_q;
  logic              ent_we;
  logic [PIX_AW+EW-1:0] ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_q, walk_wdata, new_wdata;
  logic [CHANNELS-1:0] win;
  logic              match, first;
  logic              made_c;
  logic [CNT_W-1:0]  cnt_next;
  logic [TS_W-1:0]   q_last, q_stale, run;
  lane_res_t         lres [CHANNELS];

  assign loc     = PIX_AW'(red_val);
  assign red_div = 32'(PIXELS) << red_step;

  // channel lanes
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic [VAL_W-1:0] lpix, lbnd;
    assign lpix = (c == 0) ? v0 : (c == 1) ? v1 : (c == 2) ? v2 : '0;
    assign lbnd = (c == 0) ? bound0 : (c == 1) ? bound1 : (c == 2) ? bound2 : '0;

    cbl_lane u_lane (
      .pix   (lpix),
      .bound (lbnd),
      .ll    (ent_q[c*CH_W +: VAL_W]),
      .lh    (ent_q[c*CH_W + VAL_W +: VAL_W]),
      .smin  (ent_q[c*CH_W + 2*VAL_W +: VAL_W]),
      .smax  (ent_q[c*CH_W + 3*VAL_W +: VAL_W]),
      .res   (lres[c])
    );

    assign win[c] = lres[c].in_win;
    assign walk_wdata[c*CH_W +: CH_W] = first
      ? {lres[c].smax_next, lres[c].smin_next, lres[c].lh_next, lres[c].ll_next}
      : ent_q[c*CH_W +: CH_W];
    assign new_wdata[c*CH_W +: CH_W] = {lpix, lpix, lres[c].hi, lres[c].lo};
  end

  // merge: entry matches when every lane holds its channel
  assign match   = &win;
  assign first   = pv && match && !found;
  assign q_last  = ent_q[LAST_LO +: TS_W];
  assign q_stale = ent_q[STALE_LO +: TS_W];
  assign run     = tstamp - q_last;

  assign walk_wdata[LAST_LO +: TS_W]  = first ? tstamp : q_last;
  assign walk_wdata[STALE_LO +: TS_W] = (!first && (q_stale < run)) ? run : q_stale;
  assign new_wdata[LAST_LO +: TS_W]   = tstamp;
  assign new_wdata[STALE_LO +: TS_W]  = '0;

  assign made_c   = !found && (cnt < CNT_W'(MAX_ENTRIES));
  assign cnt_next = made_c ? (cnt + CNT_W'(1)) : cnt;

  // memory port steering
  always_comb begin
    meta_we    = (state == ST_CLEAR) || (state == ST_FIN);
    meta_waddr = (state == ST_CLEAR) ? clr_addr : loc;
    meta_wdata = (state == ST_CLEAR) ? '0 : {cnt_next, tstamp};
    ent_raddr  = {loc, rd_idx[EW-1:0]};
    ent_we     = 1'b0;
    ent_waddr  = {loc, pidx};
    ent_wdata  = walk_wdata;
    if (state == ST_WALK) begin
      ent_we = pv;
    end else if (state == ST_FIN) begin
      ent_we    = made_c;
      ent_waddr = {loc, cnt[EW-1:0]};
      ent_wdata = new_wdata;
    end
  end

  cbl_ram #(.WIDTH(META_W), .DEPTH(PIXELS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (loc),
    .rdata (meta_q)
  );

  cbl_ram #(.WIDTH(ENT_W), .DEPTH(ENT_D)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_q)
  );

  // handshake outputs
  assign pix_in.ready          = (state == ST_IDLE);
  assign res_out.valid         = out_valid;
  assign res_out.matched       = out_matched;
  assign res_out.touched_entry = out_touched;
  assign res_out.created       = out_created;
  assign res_out.book_full     = out_full;
  assign res_out.entries_used  = out_used;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bound0 <= BOUND_RST;
      bound1 <= BOUND_RST;
      bound2 <= BOUND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOUND0: bound0 <= cfg_data;
        CFG_BOUND1: bound1 <= cfg_data;
        CFG_BOUND2: bound2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      pv        <= 1'b0;
      found     <= 1'b0;
    end else begin
      // result word valid: set when a word is loaded, cleared when taken
      if ((state == ST_DONE) && (!out_valid || res_out.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && res_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + PIX_AW'(1);
          if (clr_addr == PIX_AW'(PIXELS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pix_in.valid) begin
            red_val  <= pix_in.pixel_index;
            red_step <= 4'((RED_STEPS > 0) ? (RED_STEPS - 1) : 0);
            v0       <= pix_in.chan0_value;
            v1       <= pix_in.chan1_value;
            v2       <= pix_in.chan2_value;
            state    <= (RED_STEPS > 0) ? ST_RED : ST_META;
          end
        end
        ST_RED: begin
          // index modulo PIXELS, one restoring step per cycle
          if ({22'd0, red_val} >= red_div) begin
            red_val <= red_val - red_div[IDX_W-1:0];
          end
          red_step <= red_step - 4'd1;
          if (red_step == 4'd0) begin
            state <= ST_META;
          end
        end
        ST_META: begin
          state <= ST_META_RD;
        end
        ST_META_RD: begin
          cnt    <= meta_q[TS_W +: CNT_W];
          tstamp <= meta_q[TS_W-1:0] + 16'd1;
          rd_idx <= '0;
          pv     <= 1'b0;
          found  <= 1'b0;
          hit    <= '0;
          state  <= ST_WALK;
        end
        ST_WALK: begin
          // read one entry per cycle, write back the one read last cycle
          if (rd_idx != cnt) begin
            pidx   <= rd_idx[EW-1:0];
            rd_idx <= rd_idx + CNT_W'(1);
            pv     <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (first) begin
            found <= 1'b1;
            hit   <= pidx;
          end
          if ((rd_idx == cnt) && !pv) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // load the result word only once the previous one is taken
          if (!out_valid || res_out.ready) begin
            out_matched <= found;
            out_created <= made_c;
            out_full    <= !found && !made_c;
            out_touched <= found ? TOUCH_W'(hit)
                                 : (made_c ? TOUCH_W'(cnt[EW-1:0]) : '0);
            out_used    <= USED_W'(cnt_next);
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> !pix_in.ready)
    else $error("second word accepted while one is in work");

  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> !pix_in.ready)
    else $error("word accepted before clearing pass");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({out_matched, out_created, out_full}) == 1))
    else $error("result flags not exactly one of matched, created, full");

  a_full_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_full) |-> (out_touched == '0 && out_used == USED_W'(MAX_ENTRIES)))
    else $error("dropped pixel result inconsistent");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (rd_idx <= cnt))
    else $error("entry walk ran past entry count");

endmodule

/* rtl/core/cbl_ram.sv */
// cbl_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps
module cbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/cbl_lane.sv */
// cbl_lane: one channel lane, window test and entry update for one channel
// depends on cbl_pkg
`timescale 1ns / 1ps
module cbl_lane (
  input  logic [cbl_pkg::VAL_W-1:0] pix,
  input  logic [cbl_pkg::VAL_W-1:0] bound,
  input  logic [cbl_pkg::VAL_W-1:0] ll,
  input  logic [cbl_pkg::VAL_W-1:0] lh,
  input  logic [cbl_pkg::VAL_W-1:0] smin,
  input  logic [cbl_pkg::VAL_W-1:0] smax,
  output cbl_pkg::lane_res_t        res
);
  import cbl_pkg::*;

  logic [VAL_W:0]   sum;
  logic [VAL_W-1:0] hi;
  logic [VAL_W-1:0] lo;

  // learn targets pixel +/- bound, clamped to the pixel range
  assign sum = {1'b0, pix} + {1'b0, bound};
  assign hi  = sum[VAL_W] ? PIX_TOP : sum[VAL_W-1:0];
  assign lo  = (pix >= bound) ? (pix - bound) : '0;

  always_comb begin
    res.in_win    = (ll <= pix) && (pix <= lh);
    res.lo        = lo;
    res.hi        = hi;
    // learn window grows one step toward the targets
    res.lh_next   = (lh < hi) ? (lh + 8'd1) : lh;
    res.ll_next   = (ll > lo) ? (ll - 8'd1) : ll;
    // seen range widens, max checked first
    res.smax_next = (smax < pix) ? pix : smax;
    res.smin_next = (smax < pix) ? smin : ((smin > pix) ? pix : smin);
  end

endmodule

/* tb/sv/cbl_learn_checker.sv */
// cbl_learn_checker: watches the pixel, result and bound-write ports of the
// codebook learner, predicts each result word and compares it; needs cbl_pkg, cbl_if
`timescale 1ns / 1ps
module cbl_learn_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cbl_pkg::CFG_IW-1:0] cfg_index,
  input  logic [cbl_pkg::VAL_W-1:0]  cfg_data,
  cbl_in_if                          pix,
  cbl_out_if                         res,
  output int                         fails,
  output int                         pending
);
  import cbl_pkg::*;

  localparam int NPIX = DEF_PIXELS;
  localparam int NENT = DEF_MAX_ENTRIES;

  typedef struct packed {
    logic               matched;
    logic [TOUCH_W-1:0] touched_entry;
    logic               created;
    logic               book_full;
    logic [USED_W-1:0]  entries_used;
  } learn_word_t;

  // model of the learner: bounds, learn windows, entry counts
  logic [VAL_W-1:0] bound [0:2];
  logic [VAL_W-1:0] win_lo [0:NPIX*NENT-1][0:2];
  logic [VAL_W-1:0] win_hi [0:NPIX*NENT-1][0:2];
  int               book_size [0:NPIX-1];

  learn_word_t expected_words[$];
  int          errs;

  function automatic learn_word_t learn_pixel(input logic [IDX_W-1:0] loc,
                                               input logic [VAL_W-1:0] v0,
                                               input logic [VAL_W-1:0] v1,
                                               input logic [VAL_W-1:0] v2);
    learn_word_t w;
    int p[3], lo[3], hi[3];
    int base, cnt, hit, s;
    bit found, ok;
    p[0] = v0; p[1] = v1; p[2] = v2;
    for (int n = 0; n < 3; n++) begin
      hi[n] = p[n] + bound[n];
      if (hi[n] > PIX_TOP) hi[n] = PIX_TOP;
      lo[n] = p[n] - bound[n];
      if (lo[n] < 0) lo[n] = 0;
    end
    base = loc * NENT;
    cnt = book_size[loc];
    found = 0;
    hit = 0;
    w = '0;
    // first entry whose window holds every channel
    for (int e = 0; e < cnt && !found; e++) begin
      ok = 1;
      for (int n = 0; n < 3; n++)
        if (!(win_lo[base+e][n] <= p[n] && p[n] <= win_hi[base+e][n])) ok = 0;
      if (ok) begin
        found = 1;
        hit = e;
      end
    end
    if (!found && cnt < NENT) begin
      hit = cnt;
      for (int n = 0; n < 3; n++) begin
        win_lo[base+hit][n] = VAL_W'(lo[n]);
        win_hi[base+hit][n] = VAL_W'(hi[n]);
      end
      cnt++;
      book_size[loc] = cnt;
      w.created = 1;
    end else if (!found) begin
      w.book_full = 1;
    end
    // window grows one step toward pixel +/- bound
    if (!w.book_full) begin
      s = base + hit;
      for (int n = 0; n < 3; n++) begin
        if (win_hi[s][n] < hi[n]) win_hi[s][n] = win_hi[s][n] + 8'd1;
        if (win_lo[s][n] > lo[n]) win_lo[s][n] = win_lo[s][n] - 8'd1;
      end
      w.touched_entry = hit[TOUCH_W-1:0];
    end
    w.matched = found;
    w.entries_used = cnt[USED_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    learn_word_t got, want;
    if (rst) begin
      for (int n = 0; n < 3; n++) bound[n] <= BOUND_RST;
      for (int i = 0; i < NPIX; i++) book_size[i] = 0;
      expected_words.delete();
      errs = 0;
    end else begin
      // bound writes; unknown index ignored
      if (cfg_we && cfg_index <= CFG_BOUND2) bound[cfg_index] <= cfg_data;
      if (pix.valid && pix.ready)
        expected_words.push_back(learn_pixel(pix.pixel_index, pix.chan0_value,
                                             pix.chan1_value, pix.chan2_value));
      if (res.valid && res.ready) begin
        got = {res.matched, res.touched_entry, res.created, res.book_full,
               res.entries_used};
        if (expected_words.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected result word %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got.matched !== want.matched || got.touched_entry !== want.touched_entry ||
              got.created !== want.created || got.book_full !== want.book_full ||
              got.entries_used !== want.entries_used) begin
            errs++;
            if (errs <= 10) $display("result mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  assign fails   = errs;
  assign pending = expected_words.size();
endmodule

/* tb/sv/codebook_background_learn_unit_tb.sv */
// codebook_background_learn_unit_tb: drives pixel words and bound writes into the
// learner and gives the verdict; needs cbl_pkg, cbl_if, cbl_learn_checker, the RTL
`timescale 1ns / 1ps
module codebook_background_learn_unit_tb;
  import cbl_pkg::*;

  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [VAL_W-1:0]  cfg_data;
  bit                no_idle;
  int                fails, pending;
  int                rdy_hold;

  cbl_in_if  pix ();
  cbl_out_if res ();

  codebook_background_learn_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix_in(pix), .res_out(res)
  );

  cbl_learn_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix(pix), .res(res), .fails(fails), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // result side holds ready low for a random stall after each taken word, never while no_idle is set
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      rdy_hold = 0;
    end else if (res.valid && res.ready) begin
      rdy_hold = no_idle ? 0 : $urandom_range(0, 3);
      res.ready <= (rdy_hold == 0);
    end else if (rdy_hold > 0) begin
      rdy_hold--;
      res.ready <= (rdy_hold == 0);
    end else begin
      res.ready <= 1'b1;
    end
  end

  // send one pixel word, valid held high across back-to-back words
  task automatic send_pixel(input logic [IDX_W-1:0] loc, input logic [VAL_W-1:0] v0,
                            input logic [VAL_W-1:0] v1, input logic [VAL_W-1:0] v2);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.pixel_index <= loc;
    pix.chan0_value <= v0;
    pix.chan1_value <= v1;
    pix.chan2_value <= v2;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
  endtask

  // wait for every expected word, then let the walk settle
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write all bounds while idle, optionally poking the spare index
  task automatic set_bounds(input logic [VAL_W-1:0] b0, input logic [VAL_W-1:0] b1,
                            input logic [VAL_W-1:0] b2, input bit spare);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BOUND0; cfg_data <= b0; @(posedge clk);
    cfg_index <= CFG_BOUND1; cfg_data <= b1; @(posedge clk);
    cfg_index <= CFG_BOUND2; cfg_data <= b2; @(posedge clk);
    if (spare) begin
      cfg_index <= CFG_SPARE; cfg_data <= 8'($urandom_range(0, 255)); @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random words: mostly a few hot pixels with clustered colors
  task automatic random_words(input int count);
    logic [IDX_W-1:0] hot [8];
    logic [VAL_W-1:0] hue [4][3];
    logic [IDX_W-1:0] loc;
    logic [VAL_W-1:0] v [3];
    int k, j;
    for (int i = 0; i < 8; i++) hot[i] = 10'($urandom_range(0, 1023));
    for (int i = 0; i < 4; i++)
      for (int n = 0; n < 3; n++) hue[i][n] = 8'($urandom_range(0, 255));
    for (int i = 0; i < count; i++) begin
      loc = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 7)]
                                       : 10'($urandom_range(0, 1023));
      k = int'($urandom_range(0, 3));
      for (int n = 0; n < 3; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          j = int'(hue[k][n]) + int'($urandom_range(0, 8)) - 4;
          v[n] = (j < 0) ? 8'd0 : (j > 255) ? 8'd255 : j[7:0];
        end else begin
          v[n] = 8'($urandom_range(0, 255));
        end
      end
      send_pixel(loc, v[0], v[1], v[2]);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_BOUND0;
    cfg_data = '0;
    no_idle = 1'b0;
    pix.valid = 1'b0;
    pix.pixel_index = '0;
    pix.chan0_value = '0;
    pix.chan1_value = '0;
    pix.chan2_value = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, match, growth under reset bounds
    send_pixel(10'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(10'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(10'd1023, 8'd255, 8'd255, 8'd255);
    send_pixel(10'd1023, 8'd250, 8'd255, 8'd246);
    send_pixel(10'd1023, 8'd255, 8'd0, 8'd255);
    send_pixel(10'd512, 8'd170, 8'd85, 8'd60);
    drain();

    // zero width windows: only exact repeats match, book fills then drops
    set_bounds(8'd0, 8'd0, 8'd0, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel(10'd7, 8'(i * 20), 8'd1, 8'd2);
    send_pixel(10'd7, 8'd20, 8'd1, 8'd2);
    send_pixel(10'd7, 8'd200, 8'd1, 8'd2);
    drain();

    // full width windows: everything matches the first entry
    set_bounds(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(10'd300, 8'd128, 8'd0, 8'd255);
    send_pixel(10'd300, 8'd0, 8'd255, 8'd0);
    send_pixel(10'd300, 8'd255, 8'd127, 8'd1);
    drain();

    // random phases across bound settings, one with no idling
    set_bounds(8'd10, 8'd10, 8'd10, 1'b0);
    random_words(300);
    drain();
    set_bounds(8'd0, 8'd255, 8'd3, 1'b1);
    no_idle = 1'b1;
    random_words(200);
    drain();
    no_idle = 1'b0;
    set_bounds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 20)),
               8'($urandom_range(0, 8)), 1'b0);
    random_words(300);
    drain();
    set_bounds(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
               8'($urandom_range(1, 6)), 1'b0);
    random_words(300);
    drain();

    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/cbl_pkg.sv
rtl/core/cbl_if.sv
rtl/core/cbl_ram.sv
rtl/core/cbl_lane.sv
rtl/core/codebook_background_learn_unit.sv
tb/sv/cbl_learn_checker.sv
tb/sv/codebook_background_learn_unit_tb.sv
